FILE: design/tcpu_pkg.sv
// ----------------------------------------------------------------------------
// tcpu_pkg: shared definitions of the teaching CPU execute unit
// Operation codes, stream widths, parameter defaults and the request that
// starts the shared multiply/divide unit.
// ----------------------------------------------------------------------------
`default_nettype none
package tcpu_pkg;

  localparam int NUM_REGS_DEF  = 4;
  localparam int REG_WIDTH_DEF = 32;
  localparam int MEM_DEPTH_DEF = 256;   // memory depth is a power of two

  localparam int BYTE_BITS   = 8;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 48;

  localparam logic [4:0] OP_HLT  = 5'd0;
  localparam logic [4:0] OP_NOP  = 5'd1;
  localparam logic [4:0] OP_LDR  = 5'd2;
  localparam logic [4:0] OP_STR  = 5'd3;
  localparam logic [4:0] OP_ADD  = 5'd4;
  localparam logic [4:0] OP_SUB  = 5'd5;
  localparam logic [4:0] OP_MUL  = 5'd6;
  localparam logic [4:0] OP_DIV  = 5'd7;
  localparam logic [4:0] OP_CMP  = 5'd8;
  localparam logic [4:0] OP_MOVR = 5'd9;
  localparam logic [4:0] OP_AND  = 5'd10;
  localparam logic [4:0] OP_OR   = 5'd11;
  localparam logic [4:0] OP_XOR  = 5'd12;
  localparam logic [4:0] OP_NOT  = 5'd13;
  localparam logic [4:0] OP_JE   = 5'd14;
  localparam logic [4:0] OP_JNE  = 5'd15;
  localparam logic [4:0] OP_JL   = 5'd16;
  localparam logic [4:0] OP_JLE  = 5'd17;
  localparam logic [4:0] OP_JG   = 5'd18;
  localparam logic [4:0] OP_JGE  = 5'd19;
  localparam logic [4:0] OP_JMP  = 5'd20;
  localparam logic [4:0] OP_LD   = 5'd21;
  localparam logic [4:0] OP_ST   = 5'd22;
  localparam logic [4:0] OP_MOVI = 5'd23;
  localparam logic [4:0] OP_ADDI = 5'd24;
  localparam logic [4:0] OP_SUBI = 5'd25;
  localparam logic [4:0] OP_MULI = 5'd26;
  localparam logic [4:0] OP_DIVI = 5'd27;
  localparam logic [4:0] OP_LSH  = 5'd28;
  localparam logic [4:0] OP_RSH  = 5'd29;

  typedef struct packed {
    logic start;
    logic is_div;
  } md_req_t;

endpackage
`default_nettype wire

FILE: design/tcpu_muldiv.sv
// ----------------------------------------------------------------------------
// tcpu_muldiv: shared iterative multiply/divide unit
// One bit per cycle: shift-and-add multiply, restoring divide.
// ----------------------------------------------------------------------------
`default_nettype none
module tcpu_muldiv #(
  parameter int REG_WIDTH = tcpu_pkg::REG_WIDTH_DEF
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  tcpu_pkg::md_req_t      req,
  input  wire  [REG_WIDTH-1:0]   opa,
  input  wire  [REG_WIDTH-1:0]   opb,
  output logic                   done,
  output logic [REG_WIDTH-1:0]   result
);
  import tcpu_pkg::*;

  localparam int CW = $clog2(REG_WIDTH + 1);

  logic                 busy_r, busy_nxt;
  logic                 div_r;
  logic [CW-1:0]        cnt_r;
  logic [REG_WIDTH-1:0] acc_r, mcand_r, q_r;
  logic [REG_WIDTH:0]   shifted, diff;

  // A division by zero naturally yields all ones in the quotient.
  assign shifted = {acc_r, q_r[REG_WIDTH-1]};
  assign diff    = shifted - {1'b0, mcand_r};

  assign done   = busy_r && (cnt_r == '0);
  assign result = div_r ? q_r : acc_r;

  always_comb begin
    busy_nxt = busy_r;
    if (req.start) begin
      busy_nxt = 1'b1;
    end else if (done) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      div_r   <= req.is_div;
      cnt_r   <= CW'(REG_WIDTH);
      acc_r   <= '0;
      mcand_r <= req.is_div ? opb : opa;
      q_r     <= req.is_div ? opa : opb;
    end else if (busy_r && (cnt_r != '0)) begin
      cnt_r <= cnt_r - 1'b1;
      if (div_r) begin
        if (!diff[REG_WIDTH]) begin
          acc_r <= diff[REG_WIDTH-1:0];
          q_r   <= {q_r[REG_WIDTH-2:0], 1'b1};
        end else begin
          acc_r <= shifted[REG_WIDTH-1:0];
          q_r   <= {q_r[REG_WIDTH-2:0], 1'b0};
        end
      end else begin
        if (q_r[0]) begin
          acc_r <= acc_r + mcand_r;
        end
        mcand_r <= {mcand_r[REG_WIDTH-2:0], 1'b0};
        q_r     <= {1'b0, q_r[REG_WIDTH-1:1]};
      end
    end
  end

endmodule
`default_nettype wire

FILE: design/teaching_cpu_execute_unit.sv
// Sequence: an accepted beat goes to S_READ, then through S_LD1 and S_LD2 for
// loads, S_ST1 for stores or S_MD for multiply and divide, and ends in S_WB.
// Throughput: one instruction at a time; the next input beat is taken once
// the previous result is registered, so a multiply or divide holds the
// input closed until the bit-serial unit is done.
// Reset: synchronous, active low; afterwards a clearing pass zeroes the
// byte memory, during which in_tready stays low.
// ----------------------------------------------------------------------------
// teaching_cpu_execute_unit: execute stage of a small teaching CPU
// Executes one decoded instruction per input beat against a register file,
// a byte memory, the program counter and the compare flags, and returns
// one result beat with the state after the instruction.
// ----------------------------------------------------------------------------
`default_nettype none
module teaching_cpu_execute_unit #(
  parameter int NUM_REGS  = tcpu_pkg::NUM_REGS_DEF,
  parameter int REG_WIDTH = tcpu_pkg::REG_WIDTH_DEF,
  parameter int MEM_DEPTH = tcpu_pkg::MEM_DEPTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // operation[4:0], dest_index[6:5], src_index[8:7], immediate[24:9],
  // direct_address[32:25], zero fill[39:33]
  input  wire  [tcpu_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // pc_value[7:0], dest_value[39:8], equal_out[40], less_out[41],
  // greater_out[42], halted[43], zero fill[47:44]
  output logic [tcpu_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import tcpu_pkg::*;

  localparam int RIW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int AW  = $clog2(MEM_DEPTH);

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_MD    = 3'd3;
  localparam logic [2:0] S_LD1   = 3'd4;
  localparam logic [2:0] S_LD2   = 3'd5;
  localparam logic [2:0] S_ST1   = 3'd6;
  localparam logic [2:0] S_WB    = 3'd7;

  logic [2:0]   state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r;

  // Latched instruction fields.
  logic [4:0]     op_r;
  logic [RIW-1:0] d_r;
  logic [15:0]    imm_r;
  logic [7:0]     addr_r;

  // Register file: a small memory with two registered read ports.
  // Entries that were never written since reset read as zero.
  logic [REG_WIDTH-1:0] rf [NUM_REGS];
  logic [NUM_REGS-1:0]  rf_vld_r;
  logic [REG_WIDTH-1:0] a_r, b_r, res_r, res_nxt;

  // Byte memory: one write port, one registered read port.
  logic [7:0]    mem [MEM_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr, hi_addr_r, hi_addr, lo_addr;
  logic [7:0]    mem_wdata, mem_rd_r, hi_byte_r;

  logic [7:0] pc_r;
  logic       eq_r, lt_r, gt_r;
  logic       out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  md_req_t              md_req;
  logic                 md_done;
  logic [REG_WIDTH-1:0] md_result;

  // Register indices are reduced modulo NUM_REGS; the 2-bit field is below
  // twice any legal depth, so one compare and subtract suffices.
  logic [4:0]     dw, sw, dm, sm;
  logic [RIW-1:0] d_idx, s_idx;
  logic           accept, out_free;

  assign dw    = {3'b000, in_tdata[6:5]};
  assign sw    = {3'b000, in_tdata[8:7]};
  assign dm    = (dw >= 5'(NUM_REGS)) ? dw - 5'(NUM_REGS) : dw;
  assign sm    = (sw >= 5'(NUM_REGS)) ? sw - 5'(NUM_REGS) : sw;
  assign d_idx = dm[RIW-1:0];
  assign s_idx = sm[RIW-1:0];

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Memory addressing: ld/st use the direct address, ldr/str the source
  // register; the second byte's address wraps around the memory.
  logic [AW+7:0] dext;
  logic          is_direct;
  assign dext      = {{AW{1'b0}}, addr_r};
  assign is_direct = (op_r == OP_LD) || (op_r == OP_ST);
  assign hi_addr   = is_direct ? dext[AW-1:0] : b_r[AW-1:0];
  assign lo_addr   = hi_addr_r + 1'b1;

  // Shift amounts of REG_WIDTH or more give zero.
  logic                 long_sh;
  logic [REG_WIDTH-1:0] imm_ext, sh_l, sh_r;
  assign imm_ext = REG_WIDTH'(imm_r);
  assign long_sh = (imm_r >= 16'(REG_WIDTH));
  assign sh_l    = long_sh ? '0 : (a_r << imm_r);
  assign sh_r    = long_sh ? '0 : (a_r >> imm_r);

  always_comb begin
    res_nxt = res_r;
    case (op_r)
      OP_ADD:  res_nxt = a_r + b_r;
      OP_SUB:  res_nxt = a_r - b_r;
      OP_MOVR: res_nxt = b_r;
      OP_AND:  res_nxt = a_r & b_r;
      OP_OR:   res_nxt = a_r | b_r;
      OP_XOR:  res_nxt = a_r ^ b_r;
      OP_NOT:  res_nxt = REG_WIDTH'(a_r == '0);
      OP_MOVI: res_nxt = imm_ext;
      OP_ADDI: res_nxt = a_r + imm_ext;
      OP_SUBI: res_nxt = a_r - imm_ext;
      OP_LSH:  res_nxt = sh_l;
      OP_RSH:  res_nxt = sh_r;
      default: res_nxt = a_r;
    endcase
  end

  logic is_md, is_ld, is_st;
  assign is_md = (op_r == OP_MUL) || (op_r == OP_DIV) ||
                 (op_r == OP_MULI) || (op_r == OP_DIVI);
  assign is_ld = (op_r == OP_LD) || (op_r == OP_LDR);
  assign is_st = (op_r == OP_ST) || (op_r == OP_STR);

  assign md_req.start  = (state_r == S_READ) && is_md;
  assign md_req.is_div = (op_r == OP_DIV) || (op_r == OP_DIVI);

  tcpu_muldiv #(
    .REG_WIDTH (REG_WIDTH)
  ) u_muldiv (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (md_req),
    .opa    (a_r),
    .opb    (((op_r == OP_MULI) || (op_r == OP_DIVI)) ? imm_ext : b_r),
    .done   (md_done),
    .result (md_result)
  );

  // Memory write and read port selection.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = hi_addr;
    mem_wdata = a_r[15:8];
    mem_raddr = hi_addr;
    case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
      end
      S_READ: begin
        mem_we = is_st;
      end
      S_LD1: begin
        mem_raddr = lo_addr;
      end
      S_ST1: begin
        mem_we    = 1'b1;
        mem_waddr = lo_addr;
        mem_wdata = a_r[7:0];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rd_r <= mem[mem_raddr];
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == AW'(MEM_DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) state_nxt = S_READ;
      end
      S_READ: begin
        if (is_md)      state_nxt = S_MD;
        else if (is_ld) state_nxt = S_LD1;
        else if (is_st) state_nxt = S_ST1;
        else            state_nxt = S_WB;
      end
      S_MD: begin
        if (md_done) state_nxt = S_WB;
      end
      S_LD1:   state_nxt = S_LD2;
      S_LD2:   state_nxt = S_WB;
      S_ST1:   state_nxt = S_WB;
      S_WB: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Compare flags and jump decision at write-back.
  logic eq_nxt, lt_nxt, gt_nxt, jump;
  always_comb begin
    eq_nxt = eq_r;
    lt_nxt = lt_r;
    gt_nxt = gt_r;
    if (op_r == OP_CMP) begin
      eq_nxt = (a_r == b_r);
      lt_nxt = (a_r < b_r);
      gt_nxt = (a_r > b_r);
    end
    case (op_r)
      OP_JE:   jump = eq_r;
      OP_JNE:  jump = !eq_r;
      OP_JL:   jump = lt_r;
      OP_JLE:  jump = eq_r || lt_r;
      OP_JG:   jump = gt_r;
      OP_JGE:  jump = eq_r || gt_r;
      OP_JMP:  jump = 1'b1;
      default: jump = 1'b0;
    endcase
  end

  logic         wb_fire;
  logic [7:0]   pc_nxt;
  logic [REG_WIDTH+31:0] res_ext;
  assign wb_fire = (state_r == S_WB) && out_free;
  assign pc_nxt  = jump ? addr_r : pc_r;
  assign res_ext = {32'd0, res_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      rf_vld_r    <= '0;
      pc_r        <= '0;
      eq_r        <= 1'b0;
      lt_r        <= 1'b0;
      gt_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (wb_fire) begin
        rf_vld_r[d_r] <= 1'b1;
        pc_r          <= pc_nxt;
        eq_r          <= eq_nxt;
        lt_r          <= lt_nxt;
        gt_r          <= gt_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_tdata[4:0];
      d_r    <= d_idx;
      imm_r  <= in_tdata[24:9];
      addr_r <= in_tdata[32:25];
      a_r    <= rf_vld_r[d_idx] ? rf[d_idx] : '0;
      b_r    <= rf_vld_r[s_idx] ? rf[s_idx] : '0;
    end
    case (state_r)
      S_READ: begin
        res_r     <= res_nxt;
        hi_addr_r <= hi_addr;
      end
      S_MD: begin
        if (md_done) res_r <= md_result;
      end
      S_LD1: begin
        hi_byte_r <= mem_rd_r;
      end
      S_LD2: begin
        res_r <= REG_WIDTH'({hi_byte_r, mem_rd_r});
      end
      default: begin
      end
    endcase
    if (wb_fire) begin
      rf[d_r]    <= res_r;
      out_data_r <= {4'b0000, (op_r == OP_HLT), gt_nxt, lt_nxt, eq_nxt,
                     res_ext[31:0], pc_nxt};
    end
  end

endmodule
`default_nettype wire

FILE: design/tcpu_checker.sv
// ----------------------------------------------------------------------------
// tcpu_checker: port-level checks of the execute unit
// Watches the stream ports for reset, stall and one-at-a-time behavior.
// ----------------------------------------------------------------------------
`default_nettype none
module tcpu_checker (
  input wire clk,
  input wire rst_n,
  input wire in_tvalid,
  input wire in_tready,
  input wire out_tvalid,
  input wire out_tready
);
  import tcpu_pkg::*;

  // No result beat is pending right after reset.
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat valid right after reset");

  // The memory clearing pass keeps the input closed after reset.
  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_tready)
    else $error("input ready during memory clearing");

  // One instruction at a time: an accepted beat closes the input.
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted twice in a row");

  // A stalled result beat stays valid.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("stalled result beat dropped");

endmodule

bind teaching_cpu_execute_unit tcpu_checker u_tcpu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
`default_nettype wire
